FILE: src/leb_pkg.sv
// Package: constants, request codes and transfer types of the line edit buffer.
package leb_pkg;

    localparam int BUF_DEPTH_DEF = 64;
    localparam int CHAR_W        = 8;
    localparam int CAP_W         = 7;
    localparam int POS_W         = 6;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'd126;

    localparam logic [2:0] REQ_LEFT      = 3'd0;
    localparam logic [2:0] REQ_RIGHT     = 3'd1;
    localparam logic [2:0] REQ_HOME      = 3'd2;
    localparam logic [2:0] REQ_END       = 3'd3;
    localparam logic [2:0] REQ_BACKSPACE = 3'd4;
    localparam logic [2:0] REQ_DELETE    = 3'd5;
    localparam logic [2:0] REQ_INSERT    = 3'd6;
    localparam logic [2:0] REQ_READ      = 3'd7;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic              modified;
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  text_length;
        logic [CHAR_W-1:0] read_char;
    } out_item_t;

endpackage

FILE: src/leb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module leb_ram #(
    parameter int WIDTH = leb_pkg::CHAR_W,
    parameter int DEPTH = leb_pkg::BUF_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/line_edit_buffer.sv
// Top level: single-line edit buffer with cursor, shifting the text one entry per cycle.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid / in_stall  in_data  (leb_pkg::in_item_t)
//   out      from block out_valid/out_stall  out_data (leb_pkg::out_item_t)
//   cfg      to block   cfg_we               cfg_data (capacity)
//
// Cursor moves, refused edits and reads past the end are answered from idle. A read
// within the text waits in ST_RDWAIT for the registered RAM read data. Backspace and
// insert shift the tail (length - cursor entries), delete one entry fewer, in ST_SHIFT;
// then ST_FINISH updates cursor and length. One RAM read and one RAM write per cycle
// set the pace of the shift.
// One request is in work at a time; the next transfer is taken once the
// result register is free or being emptied. rst_n clears cursor, length and the
// sequencer and sets capacity to CAP_RESET; the text RAM is not cleared.
module line_edit_buffer #(
    parameter int BUF_DEPTH = leb_pkg::BUF_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  leb_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output leb_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [leb_pkg::CAP_W-1:0]      cfg_data
);

    localparam int PTR_W = $clog2(BUF_DEPTH);
    localparam int CMP_W = (PTR_W + 1 > leb_pkg::CAP_W) ? PTR_W + 1 : leb_pkg::CAP_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SHIFT  = 5'b00010,
        ST_FINISH = 5'b00100,
        ST_RDWAIT = 5'b01000,
        ST_SPARE  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [PTR_W-1:0]             cursor_reg, cursor_next;
    logic [PTR_W-1:0]             length_reg, length_next;
    logic [leb_pkg::CAP_W-1:0]    capacity_reg;
    logic [PTR_W-1:0]             src_reg, src_next;
    logic [PTR_W-1:0]             cnt_reg, cnt_next;
    logic [PTR_W-1:0]             last_reg, last_next;
    logic                         pend_reg, pend_next;
    logic [2:0]                   op_reg, op_next;
    logic [leb_pkg::CHAR_W-1:0]   ch_reg, ch_next;
    logic                         out_valid_reg, out_valid_next;
    leb_pkg::out_item_t           out_data_reg, out_data_next;

    logic                         ram_we, ram_re;
    logic [PTR_W-1:0]             ram_waddr, ram_raddr;
    logic [leb_pkg::CHAR_W-1:0]   ram_wdata, ram_rdata;

    logic                         in_take, out_take;
    logic [CMP_W-1:0]             cap_ext, eff_cap, len_ext;
    logic                         full, printable, go_right;

    leb_ram #(
        .WIDTH (leb_pkg::CHAR_W),
        .DEPTH (BUF_DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cap_ext   = CMP_W'(capacity_reg);
    assign len_ext   = CMP_W'(length_reg);
    assign printable = (in_data.char_code >= leb_pkg::CHAR_FIRST)
                    && (in_data.char_code <= leb_pkg::CHAR_LAST);
    assign go_right  = (op_reg == leb_pkg::REQ_INSERT);

    always_comb
    begin
        if (cap_ext < CMP_W'(2))
        begin
            eff_cap = CMP_W'(2);
        end
        else if (cap_ext > CMP_W'(BUF_DEPTH))
        begin
            eff_cap = CMP_W'(BUF_DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        full = (len_ext >= eff_cap - CMP_W'(1));
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        length_next    = length_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        pend_next      = 1'b0;
        op_next        = op_reg;
        ch_next        = ch_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = last_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = src_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    op_next = in_data.req_type;
                    ch_next = in_data.char_code;
                    out_data_next.modified  = 1'b0;
                    out_data_next.read_char = '0;
                    out_valid_next = 1'b1;
                    case (in_data.req_type)
                        leb_pkg::REQ_LEFT:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - PTR_W'(1);
                            end
                        end
                        leb_pkg::REQ_RIGHT:
                        begin
                            if (cursor_reg < length_reg)
                            begin
                                cursor_next = cursor_reg + PTR_W'(1);
                            end
                        end
                        leb_pkg::REQ_HOME:
                        begin
                            cursor_next = '0;
                        end
                        leb_pkg::REQ_END:
                        begin
                            cursor_next = length_reg;
                        end
                        leb_pkg::REQ_BACKSPACE:
                        begin
                            if (cursor_reg != '0)
                            begin
                                src_next       = cursor_reg;
                                cnt_next       = length_reg - cursor_reg;
                                out_valid_next = 1'b0;
                                state_next     = ST_SHIFT;
                            end
                        end
                        leb_pkg::REQ_DELETE:
                        begin
                            if (cursor_reg < length_reg)
                            begin
                                src_next       = cursor_reg + PTR_W'(1);
                                cnt_next       = length_reg - cursor_reg - PTR_W'(1);
                                out_valid_next = 1'b0;
                                state_next     = ST_SHIFT;
                            end
                        end
                        leb_pkg::REQ_INSERT:
                        begin
                            if (!full && printable)
                            begin
                                src_next       = length_reg - PTR_W'(1);
                                cnt_next       = length_reg - cursor_reg;
                                out_valid_next = 1'b0;
                                state_next     = ST_SHIFT;
                            end
                        end
                        leb_pkg::REQ_READ:
                        begin
                            if (CMP_W'(in_data.read_index) < len_ext)
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = PTR_W'(in_data.read_index);
                                out_valid_next = 1'b0;
                                state_next     = ST_RDWAIT;
                            end
                            else
                            begin
                                out_data_next.read_char = leb_pkg::CHAR_SPACE;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                    out_data_next.cursor_pos  = leb_pkg::POS_W'(cursor_next);
                    out_data_next.text_length = leb_pkg::POS_W'(length_next);
                end
            end
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = go_right ? last_reg + PTR_W'(1) : last_reg - PTR_W'(1);
                end
                if (cnt_reg != '0)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    last_next = src_reg;
                    src_next  = go_right ? src_reg - PTR_W'(1) : src_reg + PTR_W'(1);
                    cnt_next  = cnt_reg - PTR_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                case (op_reg)
                    leb_pkg::REQ_BACKSPACE:
                    begin
                        cursor_next = cursor_reg - PTR_W'(1);
                        length_next = length_reg - PTR_W'(1);
                    end
                    leb_pkg::REQ_DELETE:
                    begin
                        length_next = length_reg - PTR_W'(1);
                    end
                    default:
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = cursor_reg;
                        ram_wdata   = ch_reg;
                        cursor_next = cursor_reg + PTR_W'(1);
                        length_next = length_reg + PTR_W'(1);
                    end
                endcase
                out_valid_next            = 1'b1;
                out_data_next.modified    = 1'b1;
                out_data_next.cursor_pos  = leb_pkg::POS_W'(cursor_next);
                out_data_next.text_length = leb_pkg::POS_W'(length_next);
                out_data_next.read_char   = '0;
                state_next                = ST_IDLE;
            end
            ST_RDWAIT:
            begin
                out_valid_next          = 1'b1;
                out_data_next.read_char = ram_rdata;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            length_reg    <= '0;
            capacity_reg  <= leb_pkg::CAP_RESET;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            length_reg    <= length_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        last_reg     <= last_next;
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: src/leb_checker.sv
// Checker on the line edit buffer ports, bound to the top level.
module leb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input leb_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input leb_pkg::out_item_t out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // take no new request while a result is blocked downstream
    a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !(out_valid && out_stall))
        else $error("request taken while result blocked");

    a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.cursor_pos <= out_data.text_length)
        else $error("cursor past end of text");

    a_read_unmodified: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.modified |-> out_data.read_char == 8'd0)
        else $error("edit result carries a read character");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: tb/sv/line_edit_buffer_tb.sv
// Self-checking testbench for the line edit buffer: directed and random keystrokes against a predictor.
module line_edit_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = leb_pkg::BUF_DEPTH_DEF + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    leb_pkg::in_item_t          in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    leb_pkg::out_item_t         out_data;
    logic                       cfg_we    = 1'b0;
    logic [leb_pkg::CAP_W-1:0]  cfg_data  = leb_pkg::CAP_RESET;

    leb_pkg::in_item_t          keystrokes[$];
    leb_pkg::out_item_t         due_results[$];
    logic [leb_pkg::CHAR_W-1:0] text_shadow [leb_pkg::BUF_DEPTH_DEF];
    int                         cursor_shadow   = 0;
    int                         length_shadow   = 0;
    int                         capacity_shadow = int'(leb_pkg::CAP_RESET);

    int idle_pct   = 0;
    int stall_pct  = 0;
    bit hold_armed = 1'b0;
    bit hold_done  = 1'b0;
    int hold_count = 0;
    int errors     = 0;
    int cycles     = 0;

    line_edit_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic leb_pkg::out_item_t apply_keystroke(leb_pkg::in_item_t key);
        leb_pkg::out_item_t res;
        int                 limit;
        int                 i;
        res = '0;
        limit = (capacity_shadow < 2) ? 2 :
                ((capacity_shadow > leb_pkg::BUF_DEPTH_DEF) ? leb_pkg::BUF_DEPTH_DEF :
                 capacity_shadow);
        case (key.req_type)
            leb_pkg::REQ_LEFT:
                if (cursor_shadow > 0)
                    cursor_shadow = cursor_shadow - 1;
            leb_pkg::REQ_RIGHT:
                if (cursor_shadow < length_shadow)
                    cursor_shadow = cursor_shadow + 1;
            leb_pkg::REQ_HOME:
                cursor_shadow = 0;
            leb_pkg::REQ_END:
                cursor_shadow = length_shadow;
            leb_pkg::REQ_BACKSPACE:
                if (cursor_shadow > 0)
                begin
                    for (i = cursor_shadow; i < length_shadow; i++)
                        text_shadow[i-1] = text_shadow[i];
                    cursor_shadow = cursor_shadow - 1;
                    length_shadow = length_shadow - 1;
                    res.modified  = 1'b1;
                end
            leb_pkg::REQ_DELETE:
                if (cursor_shadow < length_shadow)
                begin
                    for (i = cursor_shadow; i + 1 < length_shadow; i++)
                        text_shadow[i] = text_shadow[i+1];
                    length_shadow = length_shadow - 1;
                    res.modified  = 1'b1;
                end
            leb_pkg::REQ_INSERT:
                if (length_shadow < limit - 1 &&
                    key.char_code >= leb_pkg::CHAR_FIRST &&
                    key.char_code <= leb_pkg::CHAR_LAST)
                begin
                    for (i = length_shadow; i > cursor_shadow; i--)
                        text_shadow[i] = text_shadow[i-1];
                    text_shadow[cursor_shadow] = key.char_code;
                    cursor_shadow = cursor_shadow + 1;
                    length_shadow = length_shadow + 1;
                    res.modified  = 1'b1;
                end
            default:
                res.read_char = (int'(key.read_index) < length_shadow) ?
                                text_shadow[key.read_index] : leb_pkg::CHAR_SPACE;
        endcase
        res.cursor_pos  = leb_pkg::POS_W'(cursor_shadow);
        res.text_length = leb_pkg::POS_W'(length_shadow);
        return res;
    endfunction

    // Driver: offer pending keystrokes, predict each transfer as it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                due_results.push_back(apply_keystroke(in_data));
            if (!in_valid || !in_stall)
            begin
                if (keystrokes.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_data  <= keystrokes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with one long hold when armed.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_armed && !hold_done)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        leb_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected transfer mod=%h cur=%h len=%h char=%h", $time,
                         out_data.modified, out_data.cursor_pos, out_data.text_length,
                         out_data.read_char);
                errors = errors + 1;
            end
            else
            begin
                want = due_results.pop_front();
                if (out_data.modified !== want.modified ||
                    out_data.cursor_pos !== want.cursor_pos ||
                    out_data.text_length !== want.text_length ||
                    out_data.read_char !== want.read_char)
                begin
                    $display("%0t: mismatch expected mod=%h cur=%h len=%h char=%h", $time,
                             want.modified, want.cursor_pos, want.text_length,
                             want.read_char);
                    $display("%0t:          actual   mod=%h cur=%h len=%h char=%h", $time,
                             out_data.modified, out_data.cursor_pos, out_data.text_length,
                             out_data.read_char);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[line_edit_buffer] ERROR");
            $finish;
        end
    end

    task automatic queue_key(logic [2:0] op, int ch, int idx);
        leb_pkg::in_item_t key;
        key.req_type   = op;
        key.char_code  = leb_pkg::CHAR_W'(ch);
        key.read_index = leb_pkg::POS_W'(idx);
        keystrokes.push_back(key);
    endtask

    task automatic queue_random(int count, int insert_pct);
        leb_pkg::in_item_t key;
        int                pick;
        repeat (count)
        begin
            key.char_code  = ($urandom_range(0, 4) == 0) ?
                             leb_pkg::CHAR_W'($urandom_range(0, 255)) :
                             leb_pkg::CHAR_W'($urandom_range(int'(leb_pkg::CHAR_FIRST),
                                                             int'(leb_pkg::CHAR_LAST)));
            key.read_index = ($urandom_range(0, 1) == 0) ?
                             leb_pkg::POS_W'($urandom_range(0, 15)) :
                             leb_pkg::POS_W'($urandom_range(0, 63));
            pick = $urandom_range(0, 99);
            if (pick < insert_pct)
                key.req_type = leb_pkg::REQ_INSERT;
            else
                case (pick % 10)
                    0, 1:    key.req_type = leb_pkg::REQ_LEFT;
                    2:       key.req_type = leb_pkg::REQ_RIGHT;
                    3:       key.req_type = leb_pkg::REQ_HOME;
                    4:       key.req_type = leb_pkg::REQ_END;
                    5, 6:    key.req_type = leb_pkg::REQ_BACKSPACE;
                    7:       key.req_type = leb_pkg::REQ_DELETE;
                    default: key.req_type = leb_pkg::REQ_READ;
                endcase
            keystrokes.push_back(key);
        end
    endtask

    // Drain: everything offered and answered, then let any late transfer surface.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (keystrokes.size() != 0 || in_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(int value);
        @(posedge clk);
        cfg_we          <= 1'b1;
        cfg_data        <= leb_pkg::CAP_W'(value);
        capacity_shadow = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_key(leb_pkg::REQ_READ, 0, 0);
        queue_key(leb_pkg::REQ_LEFT, 0, 0);
        queue_key(leb_pkg::REQ_RIGHT, 0, 0);
        queue_key(leb_pkg::REQ_BACKSPACE, 0, 0);
        queue_key(leb_pkg::REQ_DELETE, 0, 0);
        queue_key(leb_pkg::REQ_INSERT, int'(leb_pkg::CHAR_FIRST) - 1, 0);
        queue_key(leb_pkg::REQ_INSERT, int'(leb_pkg::CHAR_LAST) + 1, 0);
        queue_key(leb_pkg::REQ_INSERT, 0, 0);
        queue_key(leb_pkg::REQ_INSERT, 255, 63);
        queue_key(leb_pkg::REQ_INSERT, int'(leb_pkg::CHAR_FIRST), 0);
        queue_key(leb_pkg::REQ_INSERT, int'(leb_pkg::CHAR_LAST), 0);
        queue_key(leb_pkg::REQ_INSERT, 65, 0);
        queue_key(leb_pkg::REQ_RIGHT, 0, 0);
        queue_key(leb_pkg::REQ_LEFT, 0, 0);
        queue_key(leb_pkg::REQ_READ, 255, 1);
        queue_key(leb_pkg::REQ_READ, 0, 63);
        queue_key(leb_pkg::REQ_HOME, 0, 0);
        queue_key(leb_pkg::REQ_DELETE, 0, 0);
        queue_key(leb_pkg::REQ_END, 0, 0);
        queue_key(leb_pkg::REQ_BACKSPACE, 0, 0);
        queue_key(leb_pkg::REQ_INSERT, 90, 0);
        queue_key(leb_pkg::REQ_READ, 0, 0);
        wait_idle();

        set_capacity(0);
        queue_key(leb_pkg::REQ_INSERT, 113, 0);
        queue_key(leb_pkg::REQ_END, 0, 0);
        queue_key(leb_pkg::REQ_BACKSPACE, 0, 0);
        queue_key(leb_pkg::REQ_BACKSPACE, 0, 0);
        queue_key(leb_pkg::REQ_BACKSPACE, 0, 0);
        queue_key(leb_pkg::REQ_INSERT, 97, 0);
        queue_key(leb_pkg::REQ_INSERT, 98, 0);
        queue_key(leb_pkg::REQ_READ, 0, 0);
        wait_idle();

        set_capacity(127);
        queue_random(250, 55);
        wait_idle();

        set_capacity(10);
        idle_pct = 83;
        queue_random(200, 40);
        wait_idle();

        set_capacity(64);
        idle_pct  = 0;
        stall_pct = 83;
        queue_random(250, 45);
        wait_idle();

        set_capacity(1);
        idle_pct  = 11;
        stall_pct = 11;
        queue_random(100, 40);
        wait_idle();

        set_capacity(3);
        idle_pct  = 0;
        stall_pct = 0;
        queue_random(150, 40);
        wait_idle();

        // Hold the output long enough for the input side to back up.
        set_capacity(100);
        hold_armed = 1'b1;
        queue_random(150, 50);
        wait_idle();
        queue_random(150, 40);
        wait_idle();

        set_capacity(33);
        idle_pct  = 11;
        stall_pct = 11;
        queue_random(250, 45);
        wait_idle();

        set_capacity(64);
        idle_pct  = 83;
        stall_pct = 0;
        queue_random(200, 40);
        wait_idle();

        if (errors == 0)
            $display("[line_edit_buffer] OK");
        else
            $display("[line_edit_buffer] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/leb_pkg.sv
src/leb_ram.sv
src/line_edit_buffer.sv
src/leb_checker.sv
tb/sv/line_edit_buffer_tb.sv
